// File: hw/rtl/adsr_pkg.sv
// Package for the linear ADSR envelope generator.
// Holds state encodings, register indexes and trigger mode codes.
// No dependencies.
package adsr_pkg;

    localparam int NOTE_BITS    = 7;
    localparam int CFG_IDX_BITS = 3;

    localparam logic [CFG_IDX_BITS-1:0] CFG_ATTACK  = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DECAY   = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SUSTAIN = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_RELEASE = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_TRIGGER = 3'd4;

    localparam logic [1:0] TRIG_NONE        = 2'd0;
    localparam logic [1:0] TRIG_LEGATO      = 2'd1;
    localparam logic [1:0] TRIG_RETRIG_LEG  = 2'd2;
    localparam logic [1:0] TRIG_RETRIG_RST  = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PREP,
        ST_CALC,
        ST_FIN
    } t_state;

    typedef enum logic [1:0] {
        MDU_IDLE,
        MDU_MUL,
        MDU_DIV
    } t_mdu_phase;

    // How the quotient becomes the level
    typedef enum logic [1:0] {
        OP_DIRECT,
        OP_ADD,
        OP_SUB,
        OP_QUOT
    } t_seg_op;

endpackage

// File: hw/rtl/adsr_mdu.sv
// Iterative multiply-then-divide unit: floor(mplier * mcand / den).
// One shared adder/subtractor, shift-add multiply then restoring divide.
// Depends on adsr_pkg.
module adsr_mdu #(
    parameter int TIME_BITS  = 24,
    parameter int LEVEL_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [LEVEL_BITS-1:0] i_mplier,
    input  logic [TIME_BITS-1:0]  i_mcand,
    input  logic [TIME_BITS-1:0]  i_den,
    output logic                  o_done,
    output logic [LEVEL_BITS-1:0] o_quot
);

    localparam int PW = TIME_BITS + LEVEL_BITS;
    localparam int CW = $clog2(LEVEL_BITS);

    adsr_pkg::t_mdu_phase r_phase, n_phase;
    logic [CW-1:0]        r_cnt, n_cnt;
    logic                 r_done, n_done;
    logic [PW-1:0]        r_prod, n_prod;
    logic [TIME_BITS-1:0] r_mcand, r_den;

    logic                 sub;
    logic [TIME_BITS:0]   op_a, op_b;
    logic [TIME_BITS+1:0] sum;
    logic                 geq;
    logic [TIME_BITS-1:0] rem;
    logic                 last;

    always_comb begin
        sub  = (r_phase == adsr_pkg::MDU_DIV);
        if (sub) begin
            op_a = {r_prod[PW-1:LEVEL_BITS], r_prod[LEVEL_BITS-1]};
            op_b = {1'b0, r_den};
        end else begin
            op_a = {1'b0, r_prod[PW-1:LEVEL_BITS]};
            op_b = r_prod[0] ? {1'b0, r_mcand} : '0;
        end
        sum  = {1'b0, op_a} + (sub ? ~{1'b0, op_b} : {1'b0, op_b})
             + (TIME_BITS+2)'(sub);
        geq  = !sum[TIME_BITS+1];
        rem  = geq ? sum[TIME_BITS-1:0] : op_a[TIME_BITS-1:0];
        last = (r_cnt == CW'(LEVEL_BITS-1));

        n_phase = r_phase;
        n_cnt   = r_cnt;
        n_done  = 1'b0;
        n_prod  = r_prod;
        case (r_phase)
            adsr_pkg::MDU_IDLE: begin
                if (i_start) begin
                    n_phase = adsr_pkg::MDU_MUL;
                    n_cnt   = '0;
                    n_prod  = {{TIME_BITS{1'b0}}, i_mplier};
                end
            end
            adsr_pkg::MDU_MUL: begin
                n_prod = {sum[TIME_BITS:0], r_prod[LEVEL_BITS-1:1]};
                n_cnt  = r_cnt + CW'(1);
                if (last) begin
                    n_phase = adsr_pkg::MDU_DIV;
                    n_cnt   = '0;
                end
            end
            adsr_pkg::MDU_DIV: begin
                n_prod = {rem, r_prod[LEVEL_BITS-2:0], geq};
                n_cnt  = r_cnt + CW'(1);
                if (last) begin
                    n_phase = adsr_pkg::MDU_IDLE;
                    n_cnt   = '0;
                    n_done  = 1'b1;
                end
            end
            default: begin
                n_phase = adsr_pkg::MDU_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= adsr_pkg::MDU_IDLE;
            r_cnt   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
        if (i_start && r_phase == adsr_pkg::MDU_IDLE) begin
            r_mcand <= i_mcand;
            r_den   <= i_den;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_prod[LEVEL_BITS-1:0];

endmodule

// File: hw/rtl/adsr_envelope_generator_top.sv
// Linear ADSR envelope generator, top level.
// Instantiates adsr_mdu; uses adsr_pkg.
//
// One sample item in, one level and kill flag out. Items on an attack, decay or
// release ramp go through the shared multiply/divide unit, LEVEL_BITS shift-add
// steps then LEVEL_BITS restoring divide steps, passing the PREP, CALC and FIN
// states. Items with a fixed level (silent or unplayed notes, zero-length
// segments, sustain, finished release) pass only PREP and FIN. Input ready
// returns in the same cycle as a result appears in the output register, and is
// high only between items; a finished result sits in the output register, so the
// next item is taken while it waits, and a following result is held back until
// that one is transferred. Registers are to be written through the write port
// only while the block is idle; the block itself does not enforce this.
module adsr_envelope_generator_top #(
    parameter int TIME_BITS  = 24,
    parameter int LEVEL_BITS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [adsr_pkg::CFG_IDX_BITS-1:0]    i_cfg_idx,
    input  logic [((TIME_BITS > LEVEL_BITS) ? TIME_BITS : LEVEL_BITS)-1:0] i_cfg_wdata,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic                                 i_mono,
    input  logic                                 i_note_valid,
    input  logic [adsr_pkg::NOTE_BITS-1:0]       i_note,
    input  logic                                 i_note_active,
    input  logic                                 i_pressed,
    input  logic [TIME_BITS-1:0]                 i_elapsed,
    input  logic                                 i_latched_active,
    input  logic                                 i_latched_pressed,
    input  logic [TIME_BITS-1:0]                 i_latched_elapsed,
    input  logic [LEVEL_BITS-1:0]                i_initial_level,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic [LEVEL_BITS-1:0]                o_level,
    output logic                                 o_kill
);

    localparam logic [LEVEL_BITS-1:0] FULL = LEVEL_BITS'(1) << (LEVEL_BITS-1);

    // configuration
    logic [TIME_BITS-1:0]  r_attack, r_decay, r_release;
    logic [LEVEL_BITS-1:0] r_sustain;
    logic [1:0]            r_trig;

    // mono state
    logic [LEVEL_BITS-1:0]         r_start_level, n_start_level;
    logic [LEVEL_BITS-1:0]         r_last_level;
    logic [adsr_pkg::NOTE_BITS-1:0] r_last_note;
    logic                          r_last_known, r_last_gate;

    // item
    adsr_pkg::t_state      r_state, n_state;
    logic                  r_skip, r_upd, r_gate;
    logic [TIME_BITS-1:0]  r_t;
    logic [LEVEL_BITS-1:0] r_s;
    adsr_pkg::t_seg_op     r_op, n_op;
    logic [LEVEL_BITS-1:0] r_base, n_base;
    logic                  r_kill, n_kill;

    logic                  r_out_valid;
    logic [LEVEL_BITS-1:0] r_level;
    logic                  r_out_kill;

    // accept-time selection
    logic                          acc, use_l, c_active, c_gate, c_skip;
    logic [adsr_pkg::NOTE_BITS-1:0] c_note;
    logic [TIME_BITS-1:0]          c_t;
    logic                          was, changed;
    logic [LEVEL_BITS-1:0]         c_init, c_s;

    // segment set-up
    logic [LEVEL_BITS-1:0] sus;
    logic [TIME_BITS:0]    a_plus_d;
    logic                  mdu_start, mdu_done;
    logic [LEVEL_BITS-1:0] mdu_mplier, mdu_quot;
    logic [TIME_BITS-1:0]  mdu_mcand, mdu_den;

    logic                  fin_load;
    logic [LEVEL_BITS-1:0] fin_level;

    assign acc        = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == adsr_pkg::ST_IDLE);

    always_comb begin
        use_l    = i_mono && (r_trig == adsr_pkg::TRIG_LEGATO) && r_last_known
                   && i_latched_active;
        c_note   = use_l ? r_last_note       : i_note;
        c_active = use_l ? 1'b1              : i_note_active;
        c_gate   = use_l ? i_latched_pressed : i_pressed;
        c_t      = use_l ? i_latched_elapsed : i_elapsed;
        c_skip   = i_mono ? (!i_note_valid || !c_active) : !i_note_active;
        was      = r_last_gate;
        changed  = r_last_known && (r_last_note != c_note);

        n_start_level = r_start_level;
        case (r_trig)
            adsr_pkg::TRIG_LEGATO: begin
                if (c_gate != was) n_start_level = r_last_level;
            end
            adsr_pkg::TRIG_RETRIG_LEG: begin
                if (c_gate != was || changed) n_start_level = r_last_level;
            end
            adsr_pkg::TRIG_RETRIG_RST: begin
                if ((c_gate && !was) || changed) n_start_level = '0;
                else if (!c_gate && was)        n_start_level = r_last_level;
            end
            default: begin
                n_start_level = r_start_level;
            end
        endcase

        c_init = (i_initial_level > FULL) ? FULL : i_initial_level;
        c_s    = i_mono ? ((n_start_level > FULL) ? FULL : n_start_level) : c_init;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attack  <= TIME_BITS'(480);
            r_decay   <= TIME_BITS'(4800);
            r_sustain <= LEVEL_BITS'(22938);
            r_release <= TIME_BITS'(9600);
            r_trig    <= adsr_pkg::TRIG_NONE;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                adsr_pkg::CFG_ATTACK:  r_attack  <= i_cfg_wdata[TIME_BITS-1:0];
                adsr_pkg::CFG_DECAY:   r_decay   <= i_cfg_wdata[TIME_BITS-1:0];
                adsr_pkg::CFG_SUSTAIN: r_sustain <= i_cfg_wdata[LEVEL_BITS-1:0];
                adsr_pkg::CFG_RELEASE: r_release <= i_cfg_wdata[TIME_BITS-1:0];
                adsr_pkg::CFG_TRIGGER: r_trig    <= i_cfg_wdata[1:0];
                default: ;
            endcase
        end
    end

    // segment choice
    always_comb begin
        sus        = (r_sustain > FULL) ? FULL : r_sustain;
        a_plus_d   = {1'b0, r_attack} + {1'b0, r_decay};
        n_op       = adsr_pkg::OP_DIRECT;
        n_base     = '0;
        mdu_mplier = '0;
        mdu_mcand  = '0;
        mdu_den    = '0;
        n_kill     = !r_skip && !r_gate && (r_t > r_release);
        if (r_skip) begin
            n_op = adsr_pkg::OP_DIRECT;
        end else if (r_gate) begin
            if (r_t <= r_attack) begin
                if (r_attack == '0) begin
                    n_base = FULL;
                end else begin
                    n_op       = adsr_pkg::OP_ADD;
                    n_base     = r_s;
                    mdu_mplier = FULL - r_s;
                    mdu_mcand  = r_t;
                    mdu_den    = r_attack;
                end
            end else if ({1'b0, r_t} <= a_plus_d && r_decay != '0) begin
                n_op       = adsr_pkg::OP_SUB;
                n_base     = FULL;
                mdu_mplier = FULL - sus;
                mdu_mcand  = r_t - r_attack;
                mdu_den    = r_decay;
            end else begin
                n_base = sus;
            end
        end else if (r_t < r_release) begin
            n_op       = adsr_pkg::OP_QUOT;
            mdu_mplier = r_s;
            mdu_mcand  = r_release - r_t;
            mdu_den    = r_release;
        end
        mdu_start = (r_state == adsr_pkg::ST_PREP) && (n_op != adsr_pkg::OP_DIRECT);
    end

    adsr_mdu #(
        .TIME_BITS  (TIME_BITS),
        .LEVEL_BITS (LEVEL_BITS)
    ) u_mdu (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (mdu_start),
        .i_mplier (mdu_mplier),
        .i_mcand  (mdu_mcand),
        .i_den    (mdu_den),
        .o_done   (mdu_done),
        .o_quot   (mdu_quot)
    );

    always_comb begin
        case (r_op)
            adsr_pkg::OP_ADD:  fin_level = r_base + mdu_quot;
            adsr_pkg::OP_SUB:  fin_level = r_base - mdu_quot;
            adsr_pkg::OP_QUOT: fin_level = mdu_quot;
            default:           fin_level = r_base;
        endcase
        fin_load = (r_state == adsr_pkg::ST_FIN) && (!r_out_valid || i_out_ready);

        n_state = r_state;
        case (r_state)
            adsr_pkg::ST_IDLE: if (acc) n_state = adsr_pkg::ST_PREP;
            adsr_pkg::ST_PREP: begin
                n_state = (n_op == adsr_pkg::OP_DIRECT) ? adsr_pkg::ST_FIN
                                                        : adsr_pkg::ST_CALC;
            end
            adsr_pkg::ST_CALC: if (mdu_done) n_state = adsr_pkg::ST_FIN;
            adsr_pkg::ST_FIN:  if (fin_load) n_state = adsr_pkg::ST_IDLE;
            default:           n_state = adsr_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= adsr_pkg::ST_IDLE;
            r_out_valid   <= 1'b0;
            r_start_level <= '0;
            r_last_level  <= '0;
            r_last_note   <= '0;
            r_last_known  <= 1'b0;
            r_last_gate   <= 1'b0;
            r_upd         <= 1'b0;
        end else begin
            r_state <= n_state;
            if (acc) begin
                r_upd <= i_mono && !c_skip;
                if (i_mono && !c_skip) begin
                    r_start_level <= n_start_level;
                    r_last_note   <= c_note;
                    r_last_known  <= 1'b1;
                    r_last_gate   <= c_gate;
                end
            end
            if (fin_load) begin
                r_out_valid <= 1'b1;
                if (r_upd) r_last_level <= fin_level;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_skip <= c_skip;
            r_gate <= c_gate;
            r_t    <= c_t;
            r_s    <= c_s;
        end
        if (r_state == adsr_pkg::ST_PREP) begin
            r_op   <= n_op;
            r_base <= n_base;
            r_kill <= n_kill;
        end
        if (fin_load) begin
            r_level    <= fin_level;
            r_out_kill <= r_kill;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_level     = r_level;
    assign o_kill      = r_out_kill;

    a_done_in_calc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mdu_done |-> r_state == adsr_pkg::ST_CALC)
        else $error("divider finished outside calc state");

    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_level <= FULL)
        else $error("level above full scale");

    a_kill_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_kill) |-> o_level == '0)
        else $error("kill with non-zero level");

endmodule

// File: sim/testbench.sv
// Self-checking testbench for adsr_envelope_generator_top: clocked driver and monitor,
// an in-line envelope predictor and randomised note sequences under varying back-pressure.
// Depends on adsr_pkg and the envelope generator RTL only.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TIME_W  = 24;
    localparam int LEVEL_W = 16;
    localparam int CFG_W   = (TIME_W > LEVEL_W) ? TIME_W : LEVEL_W;
    localparam bit [63:0] FULL_LVL = 64'd1 << (LEVEL_W - 1);
    localparam bit [63:0] TIME_MAX = (64'd1 << TIME_W) - 1;
    localparam int ITEM_LATENCY = 2 * LEVEL_W + 4;

    typedef struct {
        bit              mono;
        bit              note_valid;
        bit [6:0]        note;
        bit              note_active;
        bit              pressed;
        bit [TIME_W-1:0] elapsed;
        bit              latched_active;
        bit              latched_pressed;
        bit [TIME_W-1:0] latched_elapsed;
        bit [LEVEL_W-1:0] initial_level;
        bit              drain;
    } t_sample;

    typedef struct {
        bit [LEVEL_W-1:0] level;
        bit               kill;
    } t_env_out;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [adsr_pkg::CFG_IDX_BITS-1:0] cfg_idx = '0;
    logic [CFG_W-1:0] cfg_wdata = '0;
    logic in_valid = 1'b0;
    logic in_mono = 1'b0;
    logic in_note_valid = 1'b0;
    logic [adsr_pkg::NOTE_BITS-1:0] in_note = '0;
    logic in_note_active = 1'b0;
    logic in_pressed = 1'b0;
    logic [TIME_W-1:0] in_elapsed = '0;
    logic in_latched_active = 1'b0;
    logic in_latched_pressed = 1'b0;
    logic [TIME_W-1:0] in_latched_elapsed = '0;
    logic [LEVEL_W-1:0] in_initial_level = '0;
    logic out_ready = 1'b0;
    logic in_ready;
    logic out_valid;
    logic [LEVEL_W-1:0] out_level;
    logic out_kill;

    // register shadow and mono note state
    bit [TIME_W-1:0]  cf_attack = 480;
    bit [TIME_W-1:0]  cf_decay = 4800;
    bit [LEVEL_W-1:0] cf_sustain = 22938;
    bit [TIME_W-1:0]  cf_release = 9600;
    bit [1:0]         cf_trig = adsr_pkg::TRIG_NONE;
    bit [LEVEL_W-1:0] st_start = '0;
    bit [LEVEL_W-1:0] st_last_level = '0;
    bit [6:0]         st_last_note = '0;
    bit               st_note_known = 1'b0;
    bit               st_last_gate = 1'b0;

    t_sample  pending[$];
    t_env_out level_exp[$];
    t_sample  cur;
    t_env_out exp_r;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int items_queued = 0;
    int items_accepted = 0;
    int results_seen = 0;
    int kills_seen = 0;
    int settings_used = 1;
    int errors = 0;

    adsr_envelope_generator_top #(
        .TIME_BITS (TIME_W),
        .LEVEL_BITS(LEVEL_W)
    ) i_dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_cfg_we         (cfg_we),
        .i_cfg_idx        (cfg_idx),
        .i_cfg_wdata      (cfg_wdata),
        .i_in_valid       (in_valid),
        .o_in_ready       (in_ready),
        .i_mono           (in_mono),
        .i_note_valid     (in_note_valid),
        .i_note           (in_note),
        .i_note_active    (in_note_active),
        .i_pressed        (in_pressed),
        .i_elapsed        (in_elapsed),
        .i_latched_active (in_latched_active),
        .i_latched_pressed(in_latched_pressed),
        .i_latched_elapsed(in_latched_elapsed),
        .i_initial_level  (in_initial_level),
        .o_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .o_level          (out_level),
        .o_kill           (out_kill)
    );

    function automatic bit [63:0] clamp_full(bit [63:0] v);
        return (v > FULL_LVL) ? FULL_LVL : v;
    endfunction

    function automatic bit [TIME_W-1:0] sat_ticks(bit [63:0] v);
        return (v > TIME_MAX) ? TIME_MAX[TIME_W-1:0] : v[TIME_W-1:0];
    endfunction

    // Envelope level and kill for one sample; advances the mono note state.
    function automatic t_env_out envelope_predict(t_sample x);
        t_env_out r;
        bit gate, act, was, changed;
        bit [6:0] nn;
        bit [63:0] t, s, a, d, rl, sus, v;
        r = '{default: 0};
        nn = x.note;
        act = x.note_active;
        gate = x.pressed;
        t = 64'(x.elapsed);
        if (x.mono) begin
            if (!x.note_valid) return r;
            if (cf_trig == adsr_pkg::TRIG_LEGATO && st_note_known && x.latched_active) begin
                nn = st_last_note;
                act = 1'b1;
                gate = x.latched_pressed;
                t = 64'(x.latched_elapsed);
            end
            if (!act) return r;
            was = st_last_gate;
            changed = st_note_known && (st_last_note != nn);
            case (cf_trig)
                adsr_pkg::TRIG_LEGATO: begin
                    if (gate != was) st_start = st_last_level;
                end
                adsr_pkg::TRIG_RETRIG_LEG: begin
                    if (gate != was || changed) st_start = st_last_level;
                end
                adsr_pkg::TRIG_RETRIG_RST: begin
                    if ((gate && !was) || changed) st_start = '0;
                    else if (!gate && was) st_start = st_last_level;
                end
                default: ;
            endcase
            st_last_note = nn;
            st_note_known = 1'b1;
            st_last_gate = gate;
            s = clamp_full(64'(st_start));
        end else begin
            if (!act) return r;
            s = clamp_full(64'(x.initial_level));
        end
        a = 64'(cf_attack);
        d = 64'(cf_decay);
        rl = 64'(cf_release);
        sus = clamp_full(64'(cf_sustain));
        if (gate) begin
            if (t <= a) v = (a == 0) ? FULL_LVL : s + ((FULL_LVL - s) * t) / a;
            else if (t <= a + d) v = (d == 0) ? sus : FULL_LVL - ((FULL_LVL - sus) * (t - a)) / d;
            else v = sus;
        end else begin
            v = (t >= rl) ? 64'd0 : (s * (rl - t)) / rl;
        end
        r.level = v[LEVEL_W-1:0];
        if (x.mono) st_last_level = r.level;
        r.kill = !gate && (t > rl);
        return r;
    endfunction

    // ---------------- clock and reset ----------------
    initial begin
        forever #4 clk = ~clk;
    end

    initial begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial begin
        #20ms;
        $display("testbench NOT OK");
        $finish;
    end

    // ---------------- driver ----------------
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_ready) begin
                level_exp.push_back(envelope_predict(cur));
                items_accepted++;
            end
            if (!in_valid || in_ready) begin
                if (pending.size() != 0 && !(pending[0].drain && results_seen < items_accepted)
                        && $urandom_range(99) >= send_idle_pct) begin
                    cur = pending.pop_front();
                    in_valid <= 1'b1;
                    in_mono <= cur.mono;
                    in_note_valid <= cur.note_valid;
                    in_note <= cur.note;
                    in_note_active <= cur.note_active;
                    in_pressed <= cur.pressed;
                    in_elapsed <= cur.elapsed;
                    in_latched_active <= cur.latched_active;
                    in_latched_pressed <= cur.latched_pressed;
                    in_latched_elapsed <= cur.latched_elapsed;
                    in_initial_level <= cur.initial_level;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------- monitor ----------------
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                results_seen++;
                if (out_kill) kills_seen++;
                if (level_exp.size() == 0) begin
                    errors++;
                    $display("%0t: result with none expected, level %0d kill %0b",
                             $time, out_level, out_kill);
                end else begin
                    exp_r = level_exp.pop_front();
                    if (out_level !== exp_r.level) begin
                        errors++;
                        $display("%0t: level expected %0d actual %0d",
                                 $time, exp_r.level, out_level);
                    end
                    if (out_kill !== exp_r.kill) begin
                        errors++;
                        $display("%0t: kill expected %0b actual %0b",
                                 $time, exp_r.kill, out_kill);
                    end
                end
            end
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // ---------------- stimulus ----------------
    task automatic queue_item(t_sample x);
        pending.push_back(x);
        items_queued++;
    endtask

    task automatic wait_idle();
        while (results_seen < items_queued) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic [adsr_pkg::CFG_IDX_BITS-1:0] idx, logic [CFG_W-1:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_wdata <= val;
        case (idx)
            adsr_pkg::CFG_ATTACK:  cf_attack = val[TIME_W-1:0];
            adsr_pkg::CFG_DECAY:   cf_decay = val[TIME_W-1:0];
            adsr_pkg::CFG_SUSTAIN: cf_sustain = val[LEVEL_W-1:0];
            adsr_pkg::CFG_RELEASE: cf_release = val[TIME_W-1:0];
            adsr_pkg::CFG_TRIGGER: cf_trig = val[1:0];
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic program_regs(bit [63:0] a, bit [63:0] d, bit [63:0] sus, bit [63:0] r,
                                bit [1:0] mode);
        write_reg(adsr_pkg::CFG_ATTACK, a[CFG_W-1:0]);
        write_reg(adsr_pkg::CFG_DECAY, d[CFG_W-1:0]);
        write_reg(adsr_pkg::CFG_SUSTAIN, sus[CFG_W-1:0]);
        write_reg(adsr_pkg::CFG_RELEASE, r[CFG_W-1:0]);
        write_reg(adsr_pkg::CFG_TRIGGER, CFG_W'(mode));
        settings_used++;
    endtask

    function automatic t_sample mk_item(bit mono, bit gate, bit [63:0] t, bit [15:0] init);
        t_sample x;
        x = '{default: 0};
        x.mono = mono;
        x.note_valid = 1'b1;
        x.note = 7'd60;
        x.note_active = 1'b1;
        x.pressed = gate;
        x.elapsed = sat_ticks(t);
        x.initial_level = init;
        return x;
    endfunction

    // elapsed values biased towards the segment boundaries of the current setting
    function automatic bit [TIME_W-1:0] pick_ticks();
        bit [63:0] span;
        span = 64'(cf_attack) + 64'(cf_decay) + 64'(cf_release) + 64'd4;
        if (span > 64'h7fff_ffff) span = 64'h7fff_ffff;
        case ($urandom_range(9))
            0, 1: return sat_ticks(64'($urandom));
            2: return sat_ticks(64'(cf_attack) + 64'($urandom_range(2)) - 64'd1);
            3: return sat_ticks(64'(cf_attack) + 64'(cf_decay) + 64'($urandom_range(2))
                                - 64'd1);
            4: return sat_ticks(64'(cf_release) + 64'($urandom_range(2)) - 64'd1);
            default: return sat_ticks(64'($urandom_range(0, span[31:0])));
        endcase
    endfunction

    task automatic queue_poly();
        t_sample x;
        x = '{default: 0};
        x.note_valid = 1'($urandom);
        x.note = 7'($urandom);
        x.note_active = ($urandom_range(9) != 0);
        x.pressed = 1'($urandom);
        x.elapsed = pick_ticks();
        x.latched_active = 1'($urandom);
        x.latched_pressed = 1'($urandom);
        x.latched_elapsed = TIME_W'($urandom);
        x.initial_level = ($urandom_range(4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 32768));
        queue_item(x);
    endtask

    task automatic queue_noise();
        t_sample x;
        x = '{default: 0};
        x.mono = 1'($urandom);
        x.note_valid = 1'($urandom);
        x.note = 7'($urandom);
        x.note_active = 1'($urandom);
        x.pressed = 1'($urandom);
        x.elapsed = TIME_W'($urandom);
        x.latched_active = 1'($urandom);
        x.latched_pressed = 1'($urandom);
        x.latched_elapsed = TIME_W'($urandom);
        x.initial_level = 16'($urandom);
        queue_item(x);
    endtask

    // mono note: held through attack/decay/sustain, then released towards zero
    task automatic play_note(bit drain_first);
        t_sample x;
        int hold_n, rel_n, i;
        bit [63:0] t, step_max;
        step_max = (64'(cf_attack) + 64'(cf_decay) + 64'(cf_release)) / 64'd5 + 64'd2;
        x = '{default: 0};
        x.mono = 1'b1;
        x.note = 7'($urandom);
        x.note_active = 1'b1;
        x.drain = drain_first;
        hold_n = $urandom_range(1, 8);
        rel_n = $urandom_range(1, 6);
        t = ($urandom_range(3) == 0) ? 64'($urandom_range(0, step_max[31:0])) : 64'd0;
        for (i = 0; i < hold_n + rel_n; i++) begin
            if (i == hold_n) begin
                x.pressed = 1'b0;
                t = ($urandom_range(3) == 0) ? 64'($urandom_range(0, step_max[31:0])) : 64'd0;
            end else if (i < hold_n) begin
                x.pressed = 1'b1;
                if (i != 0 && $urandom_range(9) == 0) begin
                    x.note = 7'($urandom);
                    t = 64'd0;
                end
            end
            x.note_valid = ($urandom_range(19) != 0);
            x.note_active = x.pressed || !(t > 64'(cf_release) && $urandom_range(1) != 0);
            x.elapsed = sat_ticks(t);
            x.latched_active = ($urandom_range(3) != 0);
            x.latched_pressed = 1'($urandom);
            x.latched_elapsed = sat_ticks(t + 64'($urandom_range(0, step_max[31:0])));
            x.initial_level = 16'($urandom);
            queue_item(x);
            x.drain = 1'b0;
            t += 64'($urandom_range(0, step_max[31:0]));
        end
    endtask

    initial begin
        int ph, base, pick;
        bit drained;
        t_sample x;

        // reset setting: boundaries of every segment, clamping, inactive and unplayed notes
        queue_item(mk_item(1'b0, 1'b1, 0, 16'd0));
        queue_item(mk_item(1'b0, 1'b1, 480, 16'd1000));
        queue_item(mk_item(1'b0, 1'b1, 240, 16'd32768));
        queue_item(mk_item(1'b0, 1'b1, 481, 16'd0));
        queue_item(mk_item(1'b0, 1'b1, 5280, 16'd0));
        queue_item(mk_item(1'b0, 1'b1, 5281, 16'd0));
        queue_item(mk_item(1'b0, 1'b1, TIME_MAX, 16'hFFFF));
        queue_item(mk_item(1'b0, 1'b0, 0, 16'd32768));
        queue_item(mk_item(1'b0, 1'b0, 0, 16'hFFFF));
        queue_item(mk_item(1'b0, 1'b0, 9600, 16'd32768));
        queue_item(mk_item(1'b0, 1'b0, 9601, 16'd32768));
        queue_item(mk_item(1'b0, 1'b0, TIME_MAX, 16'd20000));
        x = mk_item(1'b0, 1'b1, 100, 16'd5000);
        x.note_active = 1'b0;
        queue_item(x);
        x = mk_item(1'b1, 1'b1, 100, 16'd0);
        x.note_valid = 1'b0;
        queue_item(x);
        x = mk_item(1'b1, 1'b1, 100, 16'd0);
        x.note_active = 1'b0;
        queue_item(x);
        x = mk_item(1'b1, 1'b1, 100, 16'd0);
        x.note = 7'd127;
        queue_item(x);
        x.pressed = 1'b0;
        x.elapsed = 50;
        queue_item(x);
        x = mk_item(1'b1, 1'b1, 0, 16'd0);
        x.note = 7'd0;
        queue_item(x);

        for (ph = 0; ph < 12; ph++) begin
            wait_idle();
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 56; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 56; end
                default: begin send_idle_pct = 22; recv_stall_pct = 22; end
            endcase
            case (ph)
                0: begin
                    program_regs(0, 0, 0, 0, adsr_pkg::TRIG_NONE);
                    queue_item(mk_item(1'b0, 1'b1, 0, 16'd100));
                    queue_item(mk_item(1'b0, 1'b1, 1, 16'd100));
                    queue_item(mk_item(1'b0, 1'b0, 0, 16'd32768));
                    queue_item(mk_item(1'b0, 1'b0, 1, 16'd32768));
                end
                1: program_regs(64'($urandom_range(1, 40)), 64'($urandom_range(1, 40)),
                                64'($urandom_range(0, 32768)), 64'($urandom_range(1, 40)),
                                adsr_pkg::TRIG_LEGATO);
                2: program_regs(64'($urandom_range(0, 40)), 64'($urandom_range(0, 40)),
                                64'($urandom_range(0, 32768)), 64'($urandom_range(0, 40)),
                                adsr_pkg::TRIG_RETRIG_LEG);
                3: program_regs(64'($urandom_range(0, 40)), 64'($urandom_range(0, 40)),
                                64'($urandom_range(0, 32768)), 64'($urandom_range(0, 40)),
                                adsr_pkg::TRIG_RETRIG_RST);
                4: program_regs(TIME_MAX, TIME_MAX, 16'hFFFF, TIME_MAX,
                                adsr_pkg::TRIG_RETRIG_LEG);
                5: program_regs(0, 64'($urandom_range(0, 40)), 32768, 0, adsr_pkg::TRIG_LEGATO);
                6: begin
                    program_regs(64'($urandom_range(0, 6000)), 64'($urandom_range(0, 6000)),
                                 64'($urandom), 64'($urandom_range(0, 6000)),
                                 adsr_pkg::TRIG_NONE);
                    // unmapped index must leave every register alone
                    write_reg(adsr_pkg::CFG_TRIGGER + 3'd1, CFG_W'($urandom));
                end
                7: program_regs(1, 1, 0, 1, adsr_pkg::TRIG_RETRIG_RST);
                default: program_regs(64'($urandom_range(0, 60)), 64'($urandom_range(0, 60)),
                                      64'($urandom_range(0, 32768)),
                                      64'($urandom_range(0, 60)), 2'($urandom_range(3)));
            endcase
            base = items_queued;
            drained = 1'b0;
            while (items_queued - base < 146) begin
                pick = $urandom_range(99);
                if (pick < 65) begin
                    play_note(!drained && (items_queued - base) >= 70);
                    if ((items_queued - base) >= 70) drained = 1'b1;
                end else if (pick < 90) begin
                    queue_poly();
                end else begin
                    queue_noise();
                end
            end
        end

        wait_idle();
        repeat (2 * ITEM_LATENCY) @(posedge clk);
        $display("%0d samples transferred, %0d results checked, %0d kill flags seen",
                 items_accepted, results_seen, kills_seen);
        $display("%0d register settings, all trigger modes, poly and mono notes", settings_used);
        if (errors == 0 && results_seen == items_queued && level_exp.size() == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule
